FILE: hw/rtl/fgdc_pkg.sv
`timescale 1ns / 1ps
package fgdc_pkg;

	localparam logic [31:0] POLY32 = 32'h82F6_3B78;
	localparam logic [15:0] POLY16 = 16'hA001;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_META   = 2'd1;
	localparam logic [1:0] MODE_LEGACY = 2'd2;

	localparam int REG_INDEX_W = 3;
	localparam logic [REG_INDEX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_SEED      = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_VID_LOW   = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_VID_HIGH  = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_DESC_SIZE = 3'd4;
	localparam logic [REG_INDEX_W-1:0] REG_WIDE      = 3'd5;

	localparam logic [6:0] DESC_MIN_BYTES = 7'd32;
	localparam logic [6:0] MAX_DESC_BYTES = 7'd64;
	localparam logic [6:0] CSUM_LO        = 7'h1E;
	localparam logic [6:0] CSUM_HI        = 7'h1F;
	localparam logic [6:0] TAIL_START     = 7'h20;
	localparam logic [6:0] OFFSET_MAX     = 7'd127;
	localparam logic [6:0] DESC_SIZE_RST  = 7'd32;

	localparam int UUID_BYTES = 16;

	typedef struct packed {
		logic [31:0] grp;
		logic [7:0]  data;
		logic        first;
		logic        last;
	} stage_t;

	function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ POLY32) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ POLY16) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [31:0] prefix_step(input logic [1:0] mode, input logic [31:0] c,
			input logic [7:0] b);
		logic [31:0] r;
		case (mode)
			MODE_META: begin
				r = crc32c_byte(c, b);
			end
			MODE_LEGACY: begin
				r = {16'h0, crc16_byte(c[15:0], b)};
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] uuid_crc_zero();
		logic [15:0] c;
		c = CRC16_INIT;
		for (int i = 0; i < UUID_BYTES; i++) begin
			c = crc16_byte(c, 8'h00);
		end
		return c;
	endfunction

	localparam logic [15:0] UUID_CRC_RESET = uuid_crc_zero();

endpackage

FILE: hw/rtl/fgdc_uuid_crc.sv
`timescale 1ns / 1ps
module fgdc_uuid_crc (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] volume_id,
	output logic         busy,
	output logic [15:0]  crc
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  cur_byte;

	assign cur_byte = volume_id[{cnt_q, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			crc_q  <= fgdc_pkg::UUID_CRC_RESET;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			crc_q  <= fgdc_pkg::CRC16_INIT;
		end else if (busy_q) begin
			crc_q <= fgdc_pkg::crc16_byte(crc_q, cur_byte);
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign crc  = crc_q;

endmodule

FILE: hw/rtl/fs_group_descriptor_checksum_core.sv
`timescale 1ns / 1ps
// Block-group descriptor checksum: takes one descriptor byte per word, one word per cycle
// while input is not held off, and returns a checksum word for the byte marked last after
// it passes the input and output registers. In the input register, the group-number prefix
// (on a first byte) and the byte step are folded into the running CRC; the checksum then
// lands in the output register. A last byte waits in the input register, holding off input,
// while an earlier checksum word is still unaccepted; other bytes keep flowing. A write to
// either UUID register starts a CRC16 pass over the UUID; input and configuration are held
// off until it ends.
module fs_group_descriptor_checksum_core #(
	parameter logic [6:0] MAX_DESC_BYTES = fgdc_pkg::MAX_DESC_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fgdc_pkg::REG_INDEX_W-1:0]   cfg_index,
	input  logic [63:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [31:0]                        group_number,
	input  logic [7:0]                         data_byte,
	input  logic                               first_byte,
	input  logic                               last_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [15:0]                        checksum,
	output logic                               checksum_valid
);

	logic [1:0]  mode_q;
	logic [31:0] seed_q;
	logic [63:0] vid_low_q;
	logic [63:0] vid_high_q;
	logic [6:0]  desc_bytes_q;
	logic        wide_q;

	logic        cfg_wr;
	logic        uuid_start;
	logic        uuid_busy;
	logic [15:0] uuid_crc;

	fgdc_pkg::stage_t st_s1;
	logic vld_s1;
	logic rdy_s1;

	logic [31:0] running_crc_q;
	logic [6:0]  offset_q;
	logic        out_valid_q;
	logic [15:0] checksum_q;
	logic        checksum_valid_q;

	logic [31:0] crc_start;
	logic [31:0] prefix_crc;
	logic [31:0] base_crc;
	logic [31:0] next_crc;
	logic [6:0]  off;
	logic [6:0]  desc_span;
	logic        in_field;
	logic        in_desc;
	logic        mode_ok;
	logic        take;
	logic        in_acc;

	assign cfg_ready  = !uuid_busy;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign uuid_start = cfg_wr && (cfg_index == fgdc_pkg::REG_VID_LOW ||
		cfg_index == fgdc_pkg::REG_VID_HIGH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= fgdc_pkg::MODE_NONE;
			seed_q       <= '0;
			vid_low_q    <= '0;
			vid_high_q   <= '0;
			desc_bytes_q <= fgdc_pkg::DESC_SIZE_RST;
			wide_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				fgdc_pkg::REG_MODE:      mode_q       <= cfg_data[1:0];
				fgdc_pkg::REG_SEED:      seed_q       <= cfg_data[31:0];
				fgdc_pkg::REG_VID_LOW:   vid_low_q    <= cfg_data;
				fgdc_pkg::REG_VID_HIGH:  vid_high_q   <= cfg_data;
				fgdc_pkg::REG_DESC_SIZE: desc_bytes_q <= cfg_data[6:0];
				fgdc_pkg::REG_WIDE:      wide_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	fgdc_uuid_crc u_uuid_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (uuid_start),
		.volume_id ({vid_high_q, vid_low_q}),
		.busy      (uuid_busy),
		.crc       (uuid_crc)
	);

	// Consume the input register into the running CRC and, on the last byte, the output.
	assign take     = vld_s1 && (!st_s1.last || !out_valid_q || out_ready);
	assign rdy_s1   = !vld_s1 || take;
	assign in_ready = rdy_s1 && !uuid_busy;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1.grp   <= group_number;
			st_s1.data  <= data_byte;
			st_s1.first <= first_byte;
			st_s1.last  <= last_byte;
		end
	end

	always_comb begin
		case (mode_q)
			fgdc_pkg::MODE_META:   crc_start = seed_q;
			fgdc_pkg::MODE_LEGACY: crc_start = {16'h0, uuid_crc};
			default:               crc_start = '0;
		endcase
		prefix_crc = crc_start;
		for (int i = 0; i < 4; i++) begin
			prefix_crc = fgdc_pkg::prefix_step(mode_q, prefix_crc, st_s1.grp[8*i +: 8]);
		end
	end

	always_comb begin
		if (desc_bytes_q < fgdc_pkg::DESC_MIN_BYTES) begin
			desc_span = fgdc_pkg::DESC_MIN_BYTES;
		end else if (desc_bytes_q > MAX_DESC_BYTES) begin
			desc_span = MAX_DESC_BYTES;
		end else begin
			desc_span = desc_bytes_q;
		end
		base_crc = st_s1.first ? prefix_crc : running_crc_q;
		off      = st_s1.first ? '0 : offset_q;
		in_desc  = off < desc_span;
		in_field = (off == fgdc_pkg::CSUM_LO) || (off == fgdc_pkg::CSUM_HI);
		mode_ok  = (mode_q == fgdc_pkg::MODE_META) || (mode_q == fgdc_pkg::MODE_LEGACY);
		next_crc = base_crc;
		if (in_desc && mode_q == fgdc_pkg::MODE_META) begin
			next_crc = fgdc_pkg::crc32c_byte(base_crc, in_field ? 8'h00 : st_s1.data);
		end else if (in_desc && mode_q == fgdc_pkg::MODE_LEGACY && !in_field &&
				!(off >= fgdc_pkg::TAIL_START && !wide_q)) begin
			next_crc = {16'h0, fgdc_pkg::crc16_byte(base_crc[15:0], st_s1.data)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			offset_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				running_crc_q <= next_crc;
				offset_q      <= (off < fgdc_pkg::OFFSET_MAX) ? off + 7'd1 : off;
			end
			if (take && st_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && st_s1.last) begin
			checksum_q       <= mode_ok ? next_crc[15:0] : 16'h0;
			checksum_valid_q <= mode_ok;
		end
	end

	assign out_valid      = out_valid_q;
	assign checksum       = checksum_q;
	assign checksum_valid = checksum_valid_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		uuid_busy |-> !in_ready)
		else $error("input taken during UUID CRC pass");

	a_uuid_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		uuid_start |=> uuid_busy)
		else $error("UUID write did not start CRC pass");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !checksum_valid |-> checksum == 16'h0)
		else $error("invalid result carries nonzero checksum");

endmodule

FILE: bench/fs_group_descriptor_checksum_core_tb.sv
`timescale 1ns / 1ps
module fs_group_descriptor_checksum_core_tb;

	localparam int IDX_W = fgdc_pkg::REG_INDEX_W;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEM_TARGET   = 850;
	localparam int CFG_PAD       = 8;
	localparam int TAIL_WAIT     = 20;
	localparam int STALL_LIMIT   = 3000;

	typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_DESC, ROW_HOLD} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		logic [IDX_W-1:0]       idx;
		logic [63:0]            val;
		logic [31:0]            grp;
		logic [7:0]             fill;
		logic                   rnd;
		logic                   opens;
		logic                   closes;
		logic                   typed;
		logic [15:0]            tsum;
		logic                   tok;
	} row_t;

	typedef struct packed {
		logic [15:0] sum;
		logic        ok;
	} sum_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index;
	logic [63:0]            cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [31:0]            group_number;
	logic [7:0]             data_byte;
	logic                   first_byte;
	logic                   last_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [15:0]            checksum;
	logic                   checksum_valid;

	// side band carried with each word: a checksum typed into the table
	logic        row_typed;
	logic [15:0] typed_sum;
	logic        typed_ok;

	// predictor state and register copies
	logic [1:0]  mode_r;
	logic [31:0] seed_r;
	logic [63:0] vid_lo_r;
	logic [63:0] vid_hi_r;
	logic [6:0]  size_r;
	logic        wide_r;
	logic [31:0] crc_acc;
	logic [6:0]  byte_pos;
	logic [15:0] vid_crc_r;

	sum_word_t owed_sums[$];
	row_t      plan[$];

	int src_idle;
	int snk_idle;
	int errors;
	int words_owed;
	int words_seen;
	int sums_seen;
	int regs_written;
	logic [6:0] req_size;

	fs_group_descriptor_checksum_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] crc32c_fold(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		int          i;
		r = c;
		for (i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) r = r ^ fgdc_pkg::POLY32;
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		int          i;
		r = c;
		for (i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) r = r ^ fgdc_pkg::POLY16;
		end
		return r;
	endfunction

	function automatic logic [15:0] volume_crc(input logic [63:0] lo, input logic [63:0] hi);
		logic [127:0] id;
		logic [15:0]  c;
		int           i;
		id = {hi, lo};
		c = fgdc_pkg::CRC16_INIT;
		for (i = 0; i < fgdc_pkg::UUID_BYTES; i++) c = crc16_fold(c, id[8*i +: 8]);
		return c;
	endfunction

	function automatic int span_of(input logic [6:0] sz);
		if (sz < fgdc_pkg::DESC_MIN_BYTES) return int'(fgdc_pkg::DESC_MIN_BYTES);
		if (sz > fgdc_pkg::MAX_DESC_BYTES) return int'(fgdc_pkg::MAX_DESC_BYTES);
		return int'(sz);
	endfunction

	task automatic apply_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		case (idx)
			fgdc_pkg::REG_MODE: mode_r = val[1:0];
			fgdc_pkg::REG_SEED: seed_r = val[31:0];
			fgdc_pkg::REG_VID_LOW: begin
				vid_lo_r = val;
				vid_crc_r = volume_crc(vid_lo_r, vid_hi_r);
			end
			fgdc_pkg::REG_VID_HIGH: begin
				vid_hi_r = val;
				vid_crc_r = volume_crc(vid_lo_r, vid_hi_r);
			end
			fgdc_pkg::REG_DESC_SIZE: size_r = val[6:0];
			fgdc_pkg::REG_WIDE: wide_r = val[0];
			default: ;
		endcase
	endtask

	task automatic fold_byte(input logic [31:0] grp, input logic [7:0] b, input logic opens,
			input logic closes, output bit produced, output sum_word_t res);
		logic [31:0] c;
		logic        in_field;
		int          i;
		if (opens) begin
			byte_pos = '0;
			case (mode_r)
				fgdc_pkg::MODE_META: begin
					c = seed_r;
					for (i = 0; i < 4; i++) c = crc32c_fold(c, grp[8*i +: 8]);
				end
				fgdc_pkg::MODE_LEGACY: begin
					c = {16'h0, vid_crc_r};
					for (i = 0; i < 4; i++) c = {16'h0, crc16_fold(c[15:0], grp[8*i +: 8])};
				end
				default: c = '0;
			endcase
			crc_acc = c;
		end
		if (int'(byte_pos) < span_of(size_r)) begin
			in_field = (byte_pos == fgdc_pkg::CSUM_LO) || (byte_pos == fgdc_pkg::CSUM_HI);
			if (mode_r == fgdc_pkg::MODE_META) begin
				crc_acc = crc32c_fold(crc_acc, in_field ? 8'h00 : b);
			end else if (mode_r == fgdc_pkg::MODE_LEGACY) begin
				if (!(in_field || (byte_pos >= fgdc_pkg::TAIL_START && !wide_r)))
					crc_acc = {16'h0, crc16_fold(crc_acc[15:0], b)};
			end
		end
		if (byte_pos < fgdc_pkg::OFFSET_MAX) byte_pos = byte_pos + 7'd1;
		produced = closes;
		if (mode_r == fgdc_pkg::MODE_META || mode_r == fgdc_pkg::MODE_LEGACY) begin
			res.sum = crc_acc[15:0];
			res.ok = 1'b1;
		end else begin
			res.sum = '0;
			res.ok = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch: %s got %0h want %0h", what, got, want);
	endtask

	always @(posedge clk) begin : scoreboard
		sum_word_t want;
		bit        produced;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				sums_seen++;
				if (owed_sums.size() == 0) begin
					flag_mismatch("checksum word with none pending", 32'(checksum), 32'd0);
				end else begin
					want = owed_sums.pop_front();
					if (checksum !== want.sum)
						flag_mismatch("checksum", 32'(checksum), 32'(want.sum));
					if (checksum_valid !== want.ok)
						flag_mismatch("checksum_valid", 32'(checksum_valid), 32'(want.ok));
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_reg(cfg_index, cfg_data);
				regs_written++;
			end
			if (in_valid && in_ready) begin
				words_seen++;
				fold_byte(group_number, data_byte, first_byte, last_byte, produced, want);
				if (produced) begin
					if (row_typed) begin
						want.sum = typed_sum;
						want.ok = typed_ok;
					end
					owed_sums.push_back(want);
				end
			end
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic set_pace();
		if (words_owed < ITEM_TARGET / 3) begin
			src_idle = 24;
			snk_idle = 84;
		end else if (words_owed < 2 * ITEM_TARGET / 3) begin
			src_idle = 84;
			snk_idle = 24;
		end else begin
			src_idle = 0;
			snk_idle = 0;
		end
	endtask

	task automatic send_word(input logic [31:0] grp, input logic [7:0] b, input logic opens,
			input logic closes, input logic typed, input logic [15:0] tsum, input logic tok);
		set_pace();
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		group_number <= grp;
		data_byte <= b;
		first_byte <= opens;
		last_byte <= closes;
		row_typed <= typed;
		typed_sum <= tsum;
		typed_ok <= tok;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_owed++;
	endtask

	task automatic send_desc(input logic [31:0] grp, input int len, input logic rnd,
			input logic [7:0] fill, input logic opens, input logic typed,
			input logic [15:0] tsum, input logic tok);
		logic [7:0] b;
		int         i;
		for (i = 0; i < len; i++) begin
			b = rnd ? 8'($urandom_range(255)) : fill;
			send_word(grp, b, opens && i == 0, i == len - 1, typed && i == len - 1, tsum, tok);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_sums.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		drain_results();
		repeat (CFG_PAD) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == fgdc_pkg::REG_DESC_SIZE) req_size = val[6:0];
	endtask

	task automatic shuffle_regs();
		logic [IDX_W-1:0] idx;
		int               v;
		repeat ($urandom_range(1, 3)) begin
			idx = IDX_W'($urandom_range(0, 5));
			case (idx)
				fgdc_pkg::REG_MODE: begin
					v = $urandom_range(9);
					write_reg(fgdc_pkg::REG_MODE, 64'(v < 4 ? fgdc_pkg::MODE_META :
						v < 8 ? fgdc_pkg::MODE_LEGACY :
						v == 8 ? fgdc_pkg::MODE_NONE : MODE_UNUSED));
				end
				fgdc_pkg::REG_SEED: write_reg(fgdc_pkg::REG_SEED, 64'($urandom));
				fgdc_pkg::REG_VID_LOW: write_reg(fgdc_pkg::REG_VID_LOW, {$urandom, $urandom});
				fgdc_pkg::REG_VID_HIGH: write_reg(fgdc_pkg::REG_VID_HIGH, {$urandom, $urandom});
				fgdc_pkg::REG_DESC_SIZE: begin
					if ($urandom_range(3) != 0)
						write_reg(fgdc_pkg::REG_DESC_SIZE, 64'($urandom_range(32, 64)));
					else
						write_reg(fgdc_pkg::REG_DESC_SIZE, 64'($urandom_range(0, 127)));
				end
				default: write_reg(fgdc_pkg::REG_WIDE, 64'($urandom_range(1)));
			endcase
		end
	endtask

	function automatic row_t cfg_row(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic row_t byte_row(input logic [31:0] grp, input logic [7:0] b,
			input logic opens, input logic closes, input logic typed, input logic [15:0] tsum,
			input logic tok);
		row_t r;
		r = '0;
		r.kind = ROW_BYTE;
		r.grp = grp;
		r.fill = b;
		r.opens = opens;
		r.closes = closes;
		r.typed = typed;
		r.tsum = tsum;
		r.tok = tok;
		return r;
	endfunction

	function automatic row_t desc_row(input int len, input logic [31:0] grp,
			input logic [7:0] fill, input logic rnd, input logic typed, input logic [15:0] tsum,
			input logic tok);
		row_t r;
		r = byte_row(grp, fill, 1'b1, 1'b1, typed, tsum, tok);
		r.kind = ROW_DESC;
		r.val = 64'(len);
		r.rnd = rnd;
		return r;
	endfunction

	function automatic row_t hold_row();
		row_t r;
		r = '0;
		r.kind = ROW_HOLD;
		return r;
	endfunction

	initial begin : stimulus
		int         span;
		int         shape;
		int         roll;
		logic [31:0] grp;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		group_number = '0;
		data_byte = '0;
		first_byte = 1'b0;
		last_byte = 1'b0;
		row_typed = 1'b0;
		typed_sum = '0;
		typed_ok = 1'b0;
		mode_r = fgdc_pkg::MODE_NONE;
		seed_r = '0;
		vid_lo_r = '0;
		vid_hi_r = '0;
		size_r = fgdc_pkg::DESC_SIZE_RST;
		wide_r = 1'b0;
		crc_acc = '0;
		byte_pos = '0;
		vid_crc_r = volume_crc('0, '0);
		req_size = fgdc_pkg::DESC_SIZE_RST;
		errors = 0;
		words_owed = 0;
		words_seen = 0;
		sums_seen = 0;
		regs_written = 0;
		src_idle = 24;
		snk_idle = 84;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan = '{
			byte_row(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0),
			byte_row(32'h0, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(fgdc_pkg::MODE_META)),
			byte_row(32'h0, 8'hA5, 1'b0, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_SEED, 64'hFFFF_FFFF),
			desc_row(32, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 16'h0, 1'b0),
			desc_row(32, 32'h0, 8'h00, 1'b0, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_SEED, 64'h0),
			desc_row(5, 32'h1234_5678, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(MODE_UNUSED)),
			desc_row(3, 32'hCAFE_F00D, 8'h00, 1'b1, 1'b1, 16'h0000, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(fgdc_pkg::MODE_LEGACY)),
			desc_row(32, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_VID_LOW, 64'hFFFF_FFFF_FFFF_FFFF),
			cfg_row(fgdc_pkg::REG_VID_HIGH, 64'h0123_4567_89AB_CDEF),
			cfg_row(fgdc_pkg::REG_DESC_SIZE, 64'd64),
			desc_row(64, 32'hDEAD_BEEF, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_WIDE, 64'd1),
			desc_row(64, 32'h8000_0001, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_DESC_SIZE, 64'd127),
			desc_row(130, 32'h0F0F_0F0F, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_DESC_SIZE, 64'd0),
			desc_row(40, 32'hF0F0_F0F0, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(fgdc_pkg::MODE_META)),
			desc_row(33, 32'h5555_AAAA, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			byte_row(32'hAAAA_5555, 8'h11, 1'b1, 1'b0, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(fgdc_pkg::MODE_LEGACY)),
			byte_row(32'h0, 8'h22, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_VID_LOW, 64'h0),
			byte_row(32'h0, 8'h33, 1'b0, 1'b1, 1'b0, 16'h0, 1'b0),
			hold_row(),
			desc_row(32, 32'h0, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0),
			cfg_row(fgdc_pkg::REG_MODE, 64'(fgdc_pkg::MODE_NONE)),
			desc_row(32, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1, 16'h0000, 1'b0)
		};

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: write_reg(plan[i].idx, plan[i].val);
				ROW_BYTE: send_word(plan[i].grp, plan[i].fill, plan[i].opens, plan[i].closes,
					plan[i].typed, plan[i].tsum, plan[i].tok);
				ROW_DESC: send_desc(plan[i].grp, int'(plan[i].val), plan[i].rnd, plan[i].fill,
					1'b1, plan[i].typed, plan[i].tsum, plan[i].tok);
				default: drain_results();
			endcase
		end

		while (words_owed < ITEM_TARGET) begin
			roll = $urandom_range(99);
			if (roll < 15) shuffle_regs();
			else if (roll < 19) drain_results();
			span = span_of(req_size);
			grp = $urandom;
			shape = $urandom_range(99);
			if (shape < 55) begin
				send_desc(grp, span, 1'b1, 8'h00, 1'b1, 1'b0, 16'h0, 1'b0);
			end else if (shape < 78) begin
				send_desc(grp, int'($urandom_range(1, span - 1)), 1'b1, 8'h00, 1'b1, 1'b0,
					16'h0, 1'b0);
			end else if (shape < 86) begin
				send_desc(grp, span + int'($urandom_range(1, 8)), 1'b1, 8'h00, 1'b1, 1'b0,
					16'h0, 1'b0);
			end else if (shape < 93) begin
				send_desc(grp, int'($urandom_range(1, span)), 1'b1, 8'h00, 1'b0, 1'b0, 16'h0,
					1'b0);
			end else begin
				repeat ($urandom_range(1, 6))
					send_word($urandom, 8'($urandom_range(255)), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'b0, 16'h0, 1'b0);
			end
		end

		drain_results();
		repeat (TAIL_WAIT) @(posedge clk);
		if (owed_sums.size() != 0)
			flag_mismatch("checksum words never returned", 32'(owed_sums.size()), 32'd0);
		$display("run covered %0d input words, %0d checksum words and %0d register writes,",
			words_seen, sums_seen, regs_written);
		$display("over all four mode codes, clamped sizes, short, full and over-long descriptors");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
